/* sv/assert_macros.svh */
// Assertion macros for the RTL of the chained hash set.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define CHS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define CHS_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define CHS_ASSERT(lbl, clk, rstn, prop, msg)

`define CHS_ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* sv/chs_pkg.sv */
// Types and codes of the chained hash set: word structs, memory controls,
// operation and status codes. No dependencies.
package chs_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FIELD_W  = 4;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXISTS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DELETED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [VALUE_W-1:0] value;
  } chs_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  bucket;
    logic [FIELD_W-1:0]  position;
    logic [FIELD_W-1:0]  chain_length;
  } chs_out_t;

  typedef struct packed {
    logic slot_re;
    logic slot_we;
    logic cnt_re;
    logic cnt_we;
  } chs_mem_ctl_t;

endpackage

/* sv/chained_hash_set_unit.sv */
// Top level of the chained hash set: sequencer, remainder unit, memories.
// Depends on chs_pkg, chs_mod_unit, chs_store and assert_macros.svh.
//
//   channel | signals                           | word
//   --------+-----------------------------------+-----------
//   in      | in_valid_i, in_ready_o, in_data_i  | chs_in_t
//   out     | out_valid_o, out_ready_i, out_data_o | chs_out_t
//
// Clear: one chain count zeroed per cycle, then the result is written.
// Other words: remainder, chain count read, slot scan over the chain, then
//   a read and a write per moved slot, the new key (insert), count update, result.
// After reset every chain count is zeroed; in_ready_o is low until then.
// The result register holds a word until taken; the next word is taken meanwhile.
`include "assert_macros.svh"

module chained_hash_set_unit
  import chs_pkg::*;
#(
  parameter int unsigned BUCKETS     = 16,
  parameter int unsigned CHAIN_DEPTH = 8,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  chs_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output chs_out_t out_data_o
);

  localparam int unsigned KB    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int unsigned CNTW  = $clog2(CHAIN_DEPTH + 1);
  localparam int unsigned SLOTS = BUCKETS * CHAIN_DEPTH;
  localparam int unsigned AW    = $clog2(SLOTS);

  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CLR  = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_CNTW = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_ACT  = 4'd6;
  localparam logic [3:0] S_MRD  = 4'd7;
  localparam logic [3:0] S_MWR  = 4'd8;
  localparam logic [3:0] S_INS  = 4'd9;
  localparam logic [3:0] S_UPD  = 4'd10;
  localparam logic [3:0] S_FIN  = 4'd11;

  logic [3:0]          state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic [BW-1:0]       clr_q, clr_d;
  logic [OP_W-1:0]     op_q, op_d;
  logic [KB-1:0]       key_q, key_d;
  logic [BW-1:0]       bkt_q, bkt_d;
  logic [AW-1:0]       base_q, base_d;
  logic [CNTW-1:0]     len_q, len_d;
  logic [CNTW-1:0]     idx_q, idx_d;
  logic [CNTW-1:0]     cmp_q, cmp_d;
  logic [CNTW-1:0]     pos_q, pos_d;
  logic [CNTW-1:0]     src_q, src_d;
  logic [CNTW-1:0]     dst_q, dst_d;
  logic [CNTW-1:0]     moves_q, moves_d;
  logic                pend_q, pend_d;
  logic                hit_q, hit_d;
  logic [STATUS_W-1:0] status_q, status_d;
  chs_out_t            out_q, out_d;

  logic                mod_start, mod_done;
  logic [BW-1:0]       mod_rem;
  chs_mem_ctl_t        mem_ctl;
  logic [CNTW-1:0]     slot_off;
  logic [AW-1:0]       slot_addr;
  logic [KB-1:0]       slot_wdata, slot_rdata;
  logic [BW-1:0]       cnt_addr;
  logic [CNTW-1:0]     cnt_wdata, cnt_rdata;
  logic                in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign mod_start  = in_acc && (in_data_i.operation != OP_CLEAR);
  assign slot_addr  = base_q + AW'(slot_off);

  chs_mod_unit #(
    .KEY_BITS (KB),
    .DIVISOR  (BUCKETS)
  ) u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .key_i   (in_data_i.value[KB-1:0]),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  chs_store #(
    .BUCKETS     (BUCKETS),
    .CHAIN_DEPTH (CHAIN_DEPTH),
    .KEY_BITS    (KB)
  ) u_store (
    .clk_i        (clk_i),
    .ctl_i        (mem_ctl),
    .slot_addr_i  (slot_addr),
    .slot_wdata_i (slot_wdata),
    .slot_rdata_o (slot_rdata),
    .cnt_addr_i   (cnt_addr),
    .cnt_wdata_i  (cnt_wdata),
    .cnt_rdata_o  (cnt_rdata)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    clr_d       = clr_q;
    op_d        = op_q;
    key_d       = key_q;
    bkt_d       = bkt_q;
    base_d      = base_q;
    len_d       = len_q;
    idx_d       = idx_q;
    cmp_d       = cmp_q;
    pos_d       = pos_q;
    src_d       = src_q;
    dst_d       = dst_q;
    moves_d     = moves_q;
    pend_d      = pend_q;
    hit_d       = hit_q;
    status_d    = status_q;
    out_d       = out_q;
    mem_ctl     = '0;
    slot_off    = '0;
    slot_wdata  = key_q;
    cnt_addr    = bkt_q;
    cnt_wdata   = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_INIT, S_CLR: begin
        mem_ctl.cnt_we = 1'b1;
        cnt_addr       = clr_q;
        clr_d          = clr_q + BW'(1);
        if (clr_q == BW'(BUCKETS - 1)) begin
          clr_d    = '0;
          status_d = ST_CLEARED;
          state_d  = (state_q == S_INIT) ? S_IDLE : S_FIN;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d   = in_data_i.operation;
          key_d  = in_data_i.value[KB-1:0];
          pos_d  = '0;
          hit_d  = 1'b0;
          if (in_data_i.operation == OP_CLEAR) begin
            bkt_d   = '0;
            len_d   = '0;
            clr_d   = '0;
            state_d = S_CLR;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (mod_done) begin
          mem_ctl.cnt_re = 1'b1;
          cnt_addr       = mod_rem;
          bkt_d          = mod_rem;
          base_d         = AW'(mod_rem) * AW'(CHAIN_DEPTH);
          state_d        = S_CNTW;
        end
      end
      S_CNTW: begin
        len_d   = cnt_rdata;
        idx_d   = '0;
        pend_d  = 1'b0;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        slot_off = idx_q;
        if (pend_q && (slot_rdata == key_q)) begin
          hit_d   = 1'b1;
          pos_d   = cmp_q;
          state_d = S_ACT;
        end else if (pend_q && (CNTW'(cmp_q + CNTW'(1)) == len_q)) begin
          state_d = S_ACT;
        end else if (len_q == '0) begin
          state_d = S_ACT;
        end else begin
          mem_ctl.slot_re = 1'b1;
          cmp_d           = idx_q;
          pend_d          = 1'b1;
          idx_d           = idx_q + CNTW'(1);
        end
      end
      S_ACT: begin
        case (op_q)
          OP_INSERT: begin
            if (hit_q) begin
              status_d = ST_EXISTS;
              state_d  = S_FIN;
            end else if (len_q == CNTW'(CHAIN_DEPTH)) begin
              status_d = ST_FULL;
              state_d  = S_FIN;
            end else begin
              moves_d = len_q;
              src_d   = len_q - CNTW'(1);
              dst_d   = len_q;
              state_d = (len_q == '0) ? S_INS : S_MRD;
            end
          end
          OP_DELETE: begin
            if (hit_q) begin
              moves_d = len_q - pos_q - CNTW'(1);
              src_d   = pos_q + CNTW'(1);
              dst_d   = pos_q;
              state_d = (CNTW'(pos_q + CNTW'(1)) == len_q) ? S_UPD : S_MRD;
            end else begin
              status_d = ST_NOTFOUND;
              state_d  = S_FIN;
            end
          end
          default: begin
            status_d = hit_q ? ST_FOUND : ST_NOTFOUND;
            state_d  = S_FIN;
          end
        endcase
      end
      S_MRD: begin
        slot_off        = src_q;
        mem_ctl.slot_re = 1'b1;
        state_d         = S_MWR;
      end
      S_MWR: begin
        slot_off        = dst_q;
        slot_wdata      = slot_rdata;
        mem_ctl.slot_we = 1'b1;
        moves_d         = moves_q - CNTW'(1);
        if (op_q == OP_INSERT) begin
          src_d = src_q - CNTW'(1);
          dst_d = dst_q - CNTW'(1);
        end else begin
          src_d = src_q + CNTW'(1);
          dst_d = dst_q + CNTW'(1);
        end
        if (moves_q == CNTW'(1)) begin
          state_d = (op_q == OP_INSERT) ? S_INS : S_UPD;
        end else begin
          state_d = S_MRD;
        end
      end
      S_INS: begin
        slot_off        = '0;
        slot_wdata      = key_q;
        mem_ctl.slot_we = 1'b1;
        state_d         = S_UPD;
      end
      S_UPD: begin
        mem_ctl.cnt_we = 1'b1;
        cnt_addr       = bkt_q;
        if (op_q == OP_INSERT) begin
          cnt_wdata = len_q + CNTW'(1);
          status_d  = ST_INSERTED;
        end else begin
          cnt_wdata = len_q - CNTW'(1);
          status_d  = ST_DELETED;
        end
        len_d   = cnt_wdata;
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status       = status_q;
          out_d.bucket       = FIELD_W'(bkt_q);
          out_d.position     = FIELD_W'(pos_q);
          out_d.chain_length = FIELD_W'(len_q);
          out_valid_d        = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    bkt_q    <= bkt_d;
    base_q   <= base_d;
    len_q    <= len_d;
    idx_q    <= idx_d;
    cmp_q    <= cmp_d;
    pos_q    <= pos_d;
    src_q    <= src_d;
    dst_q    <= dst_d;
    moves_q  <= moves_d;
    pend_q   <= pend_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CHS_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_acc |=> !in_ready_o, "ready after accept")
  `CHS_ASSERT(a_fin_holds, clk_i, rst_ni, (state_q == S_FIN && out_valid_q && !out_ready_i) |=> (state_q == S_FIN), "result overwritten")
  `CHS_ASSERT_NEVER(a_scan_empty, clk_i, rst_ni, (state_q == S_SCAN) && pend_q && (len_q == '0), "scan of empty chain")
  `CHS_ASSERT_NEVER(a_move_count, clk_i, rst_ni, (state_q == S_MWR) && (moves_q == '0), "move without count")

endmodule

/* sv/chs_mod_unit.sv */
// Remainder by a constant divisor: reciprocal multiply for the quotient, then
// multiply back and subtract; done_o rises with the remainder. No dependencies.
module chs_mod_unit #(
  parameter int unsigned KEY_BITS = 16,
  parameter int unsigned DIVISOR  = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [KEY_BITS-1:0] key_i,
  output logic                done_o,
  output logic [((DIVISOR > 1) ? $clog2(DIVISOR) : 1)-1:0] rem_o
);

  localparam int unsigned BW = (DIVISOR > 1) ? $clog2(DIVISOR) : 1;
  localparam int unsigned SH = KEY_BITS + BW;
  localparam int unsigned MW = KEY_BITS + 2;
  localparam int unsigned PW = SH + KEY_BITS;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);

  logic                v1_q, v2_q, done_q;
  logic [KEY_BITS-1:0] key_q, quo_q, quo_d, back;
  logic [BW-1:0]       rem_q, rem_d;
  logic [PW-1:0]       prod;

  always_comb begin
    prod  = PW'(key_q) * PW'(MW'(RECIP));
    quo_d = prod[SH +: KEY_BITS];
    back  = quo_q * KEY_BITS'(DIVISOR);
    rem_d = BW'(key_q - back);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      key_q <= key_i;
    end
    if (v1_q) begin
      quo_q <= quo_d;
    end
    if (v2_q) begin
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* sv/chs_store.sv */
// Slot and chain count memories, one port each, registered read data.
// Depends on chs_pkg for the memory control struct.
module chs_store
  import chs_pkg::*;
#(
  parameter int unsigned BUCKETS     = 16,
  parameter int unsigned CHAIN_DEPTH = 8,
  parameter int unsigned KEY_BITS    = 16
) (
  input  logic                                  clk_i,
  input  chs_mem_ctl_t                          ctl_i,
  input  logic [$clog2(BUCKETS*CHAIN_DEPTH)-1:0] slot_addr_i,
  input  logic [KEY_BITS-1:0]                   slot_wdata_i,
  output logic [KEY_BITS-1:0]                   slot_rdata_o,
  input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] cnt_addr_i,
  input  logic [$clog2(CHAIN_DEPTH+1)-1:0]      cnt_wdata_i,
  output logic [$clog2(CHAIN_DEPTH+1)-1:0]      cnt_rdata_o
);

  localparam int unsigned SLOTS = BUCKETS * CHAIN_DEPTH;
  localparam int unsigned CNTW  = $clog2(CHAIN_DEPTH + 1);

  logic [KEY_BITS-1:0] slot_mem [SLOTS];
  logic [CNTW-1:0]     cnt_mem  [BUCKETS];

  always_ff @(posedge clk_i) begin
    if (ctl_i.slot_we) begin
      slot_mem[slot_addr_i] <= slot_wdata_i;
    end
    if (ctl_i.slot_re) begin
      slot_rdata_o <= slot_mem[slot_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.cnt_we) begin
      cnt_mem[cnt_addr_i] <= cnt_wdata_i;
    end
    if (ctl_i.cnt_re) begin
      cnt_rdata_o <= cnt_mem[cnt_addr_i];
    end
  end

endmodule

/* verif/tb_top.sv */
// Self-checking bench for chained_hash_set_unit: directed chain cases, random
// insert/delete/search/clear traffic, and a long output stall.
// Depends on chs_pkg and the chained_hash_set_unit RTL.
module tb_top;
  import chs_pkg::*;

  localparam int unsigned BUCKETS       = 16;
  localparam int unsigned CHAIN_DEPTH   = 8;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned MAX_REPORTS   = 10;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  chs_in_t  in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  chs_out_t out_data_o;

  chained_hash_set_unit #(
    .BUCKETS    (BUCKETS),
    .CHAIN_DEPTH(CHAIN_DEPTH),
    .VALUE_BITS (VALUE_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  logic [VALUE_W-1:0] set_slots [BUCKETS][CHAIN_DEPTH];
  int unsigned        set_counts [BUCKETS];
  chs_out_t           expected_results [$];

  int unsigned cycle_count   = 0;
  int unsigned mismatches    = 0;
  int unsigned words_sent    = 0;
  int unsigned words_checked = 0;
  int unsigned op_tally [4];
  int unsigned status_tally [8];
  bit          send_gaps_on  = 1'b1;
  bit          recv_gaps_on  = 1'b1;
  bit          hold_req      = 1'b0;
  bit          hold_done     = 1'b0;

  function automatic chs_out_t hash_set_apply(chs_in_t w);
    chs_out_t    r;
    int unsigned b;
    int unsigned len;
    int          hit;
    r = '0;
    if (w.operation == OP_CLEAR) begin
      foreach (set_counts[i]) set_counts[i] = 0;
      r.status = ST_CLEARED;
      return r;
    end
    b   = w.value % BUCKETS;
    len = set_counts[b];
    hit = -1;
    for (int i = 0; i < len; i++) begin
      if (hit < 0 && set_slots[b][i] == w.value) hit = i;
    end
    case (w.operation)
      OP_INSERT: begin
        if (hit >= 0) begin
          r.status   = ST_EXISTS;
          r.position = FIELD_W'(hit);
        end else if (len >= CHAIN_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = len; i > 0; i--) set_slots[b][i] = set_slots[b][i-1];
          set_slots[b][0] = w.value;
          len++;
          set_counts[b] = len;
          r.status      = ST_INSERTED;
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          r.position = FIELD_W'(hit);
          for (int i = hit; i + 1 < len; i++) set_slots[b][i] = set_slots[b][i+1];
          len--;
          set_counts[b] = len;
          r.status      = ST_DELETED;
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
      default: begin
        if (hit >= 0) begin
          r.status   = ST_FOUND;
          r.position = FIELD_W'(hit);
        end else begin
          r.status = ST_NOTFOUND;
        end
      end
    endcase
    r.bucket       = FIELD_W'(b);
    r.chain_length = FIELD_W'(len);
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_INSERT;
    if (r < 70) return OP_DELETE;
    if (r < 97) return OP_SEARCH;
    return OP_CLEAR;
  endfunction

  // Keep keys in a small pool per bucket so chains fill, collide and empty.
  function automatic logic [VALUE_W-1:0] pick_value(int unsigned hot_buckets);
    int unsigned r;
    logic [3:0]  b;
    logic [11:0] high;
    r = $urandom_range(0, 99);
    if (r < 12) return VALUE_W'($urandom());
    b = 4'($urandom_range(0, hot_buckets - 1));
    if (r < 25) high = 12'hFFF - 12'($urandom_range(0, 3));
    else        high = 12'($urandom_range(0, 10));
    return {high, b};
  endfunction

  task automatic send_word(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] val);
    chs_in_t     w;
    chs_out_t    res;
    int unsigned gap;
    w.operation = op;
    w.value     = val;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    res = hash_set_apply(w);
    expected_results.push_back(res);
    words_sent++;
    op_tally[op]++;
    status_tally[res.status]++;
  endtask

  task automatic report_mismatch(input string what, input chs_out_t e, input chs_out_t a);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%s: expected status %0d bucket %0d position %0d length %0d, got status %0d bucket %0d position %0d length %0d",
               what, e.status, e.bucket, e.position, e.chain_length,
               a.status, a.bucket, a.position, a.chain_length);
    end
  endtask

  always @(posedge clk_i) begin
    chs_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", '0, out_data_o);
      end else begin
        e = expected_results.pop_front();
        words_checked++;
        if (out_data_o.status !== e.status || out_data_o.bucket !== e.bucket ||
            out_data_o.position !== e.position ||
            out_data_o.chain_length !== e.chain_length) begin
          report_mismatch("mismatch", e, out_data_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, expected_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      gap = recv_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic test_directed_chains();
    logic [VALUE_W-1:0] fill [8];
    fill = '{16'd15, 16'd31, 16'd47, 16'd63, 16'd79, 16'd95, 16'd111, 16'hFFFF};
    foreach (fill[i]) send_word(OP_INSERT, fill[i]);
    send_word(OP_INSERT, 16'd127);
    send_word(OP_INSERT, 16'd31);
    send_word(OP_SEARCH, 16'hFFFF);
    send_word(OP_SEARCH, 16'd0);
    send_word(OP_DELETE, 16'd15);
    send_word(OP_DELETE, 16'd79);
    send_word(OP_DELETE, 16'hFFFF);
    send_word(OP_DELETE, 16'd15);
    send_word(OP_DELETE, 16'd0);
    send_word(OP_INSERT, 16'd0);
    send_word(OP_SEARCH, 16'd0);
    send_word(OP_CLEAR, 16'hFFFF);
    send_word(OP_SEARCH, 16'd31);
    send_word(OP_INSERT, 16'd31);
  endtask

  task automatic test_random_mixed(input int unsigned count);
    repeat (count) send_word(pick_op(), pick_value(BUCKETS));
  endtask

  task automatic test_output_backpressure();
    send_gaps_on = 1'b0;
    hold_req     = 1'b1;
    repeat (40) send_word(pick_op(), pick_value(4));
    in_valid_i <= 1'b0;
    wait (hold_done);
    @(posedge clk_i);
    send_gaps_on = 1'b1;
  endtask

  task automatic test_random_bursts(input int unsigned count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        send_gaps_on = ((i / 50) % 2) != 0;
        recv_gaps_on = ((i / 50) % 2) != 0;
      end
      send_word(pick_op(), pick_value(4));
    end
    send_gaps_on = 1'b1;
    recv_gaps_on = 1'b1;
  endtask

  task automatic wait_for_drain();
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_chains();
    test_random_mixed(350);
    test_output_backpressure();
    test_random_bursts(340);
    in_valid_i <= 1'b0;
    wait_for_drain();
    $display("ran %0d words (%0d insert, %0d delete, %0d search, %0d clear), %0d results checked",
             words_sent, op_tally[OP_INSERT], op_tally[OP_DELETE], op_tally[OP_SEARCH],
             op_tally[OP_CLEAR], words_checked);
    $display("outcomes: %0d inserted, %0d duplicate, %0d bucket full, %0d deleted, %0d missing, %0d found",
             status_tally[ST_INSERTED], status_tally[ST_EXISTS], status_tally[ST_FULL],
             status_tally[ST_DELETED], status_tally[ST_NOTFOUND], status_tally[ST_FOUND]);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/chs_pkg.sv
sv/chs_mod_unit.sv
sv/chs_store.sv
sv/chained_hash_set_unit.sv
verif/tb_top.sv
